FILE: src/tmb_pkg.sv
// tempo map package: entry type, command, status and register index codes, arithmetic widths
// no dependencies
`default_nettype none
package tmb_pkg;

  localparam int BEAT_W  = 32;
  localparam int TEMPO_W = 16;
  localparam int RATE_W  = 19;
  localparam int OUT_W   = 48;
  localparam int NUM_W   = 45;  // delta * 7680 + tempo/2 fits in 45 bits
  localparam int ACC_W   = 51;  // up to 17 segments of 45 bits
  localparam int SECONDS_PER_MIN_Q7 = 7680;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_CONVERT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_DEFAULT_TEMPO = 1'b0,
    REG_SAMPLE_RATE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [BEAT_W-1:0]  beat;
    logic [TEMPO_W-1:0] tempo;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/tmb_in_if.sv
// input channel: command, beat position, change tempo
// depends on nothing
`default_nettype none
interface tmb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] beat_pos;
  logic [15:0] change_tempo;
  modport source (output valid, command, beat_pos, change_tempo, input ready);
  modport sink (input valid, command, beat_pos, change_tempo, output ready);
endinterface
`default_nettype wire

FILE: src/tmb_out_if.sv
// result channel: tempo, elapsed seconds, sample frame, status
// depends on nothing
`default_nettype none
interface tmb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tempo_now;
  logic [47:0] elapsed_seconds;
  logic [47:0] sample_frame;
  logic [1:0]  status;
  modport source (output valid, tempo_now, elapsed_seconds, sample_frame, status,
                  input ready);
  modport sink (input valid, tempo_now, elapsed_seconds, sample_frame, status,
                output ready);
endinterface
`default_nettype wire

FILE: src/tmb_cfg_if.sv
// configuration write channel: register index and write data
// depends on nothing
`default_nettype none
interface tmb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [18:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/tmb_cell.sv
// one tempo map entry of the sorted chain; shifts to its neighbor on insert
// depends on tmb_pkg
`default_nettype none
module tmb_cell (
  input  wire logic            clk,
  input  wire logic            ins,
  input  wire tmb_pkg::entry_t new_entry,
  input  wire tmb_pkg::entry_t prev_entry,
  input  wire logic            prev_gt,
  input  wire logic            used,
  input  wire logic            at_end,
  output tmb_pkg::entry_t      entry,
  output logic                 gt
);
  import tmb_pkg::*;

  assign gt = used && (entry.beat > new_entry.beat);

  always_ff @(posedge clk) begin
    if (ins) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (gt || at_end) begin
        entry <= new_entry;
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/tmb_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on tmb_pkg
`default_nettype none
module tmb_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tmb_pkg::NUM_W-1:0]   num,
  input  wire logic [tmb_pkg::TEMPO_W-1:0] den,
  output logic                             done,
  output logic [tmb_pkg::NUM_W-1:0]        quot
);
  import tmb_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [TEMPO_W-1:0] rem;
  logic [TEMPO_W-1:0] dv;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [TEMPO_W:0]   trial;

  assign trial = {rem, quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        quot <= num;
        dv   <= den;
      end else if (busy) begin
        // numerator bits shift out the top while quotient bits shift in
        if (trial >= {1'b0, dv}) begin
          rem  <= TEMPO_W'(trial - {1'b0, dv});
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial[TEMPO_W-1:0];
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/tempo_map_beat_to_time_core.sv
// tempo map beat to time converter, top level
// depends on tmb_pkg, tmb_in_if, tmb_out_if, tmb_cfg_if, tmb_cell, tmb_div
`default_nettype none
// The tempo map lives in a chain of MAP_DEPTH cells kept sorted by beat; an
// insert shifts the later cells one place at once, and clear and insert go
// from the transfer through the result state back to idle. A convert walks
// the map one segment at a time: every non-empty segment takes a setup step,
// the divider's run and an accumulate step, an empty segment takes only the
// setup step, and the walk is followed by the frame product, the final sum
// and the result register. A full map of the default depth holds 16 changes
// (17 segments). One item is in work at a time; the result register holds a
// finished result while the next item is accepted.
module tempo_map_beat_to_time_core #(
  parameter int MAP_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tmb_in_if.sink    in_ch,
  tmb_out_if.source out_ch,
  tmb_cfg_if.sink   cfg
);
  import tmb_pkg::*;

  localparam int CW = $clog2(MAP_DEPTH + 1);
  localparam int IW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [OUT_W-1:0] MAX48 = '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SEG  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SUM  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [TEMPO_W-1:0] default_tempo;
  logic [RATE_W-1:0]  sample_rate;
  logic [CW-1:0]      count;

  entry_t             entries [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] gts;
  entry_t             new_entry;
  logic               ins;

  logic [BEAT_W-1:0]  q;
  logic [BEAT_W-1:0]  last;
  logic [TEMPO_W-1:0] tempo_cur;
  logic [CW-1:0]      idx;
  logic               fin;
  logic               bad;
  logic [ACC_W-1:0]   acc;
  logic [OUT_W-1:0]   secs;
  logic               sat;
  logic [50:0]        p_hi;
  logic [34:0]        p_lo;

  logic [TEMPO_W-1:0] res_tempo;
  logic [OUT_W-1:0]   res_secs;
  logic [OUT_W-1:0]   res_frame;
  status_t            res_status;

  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [NUM_W-1:0]   div_quot;
  logic [TEMPO_W-1:0] seg_tempo;

  logic               in_xfer;
  logic               full;
  entry_t             rd;
  logic               take;
  logic [BEAT_W-1:0]  delta;
  logic [52:0]        frame_sum;

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign full        = (count >= CW'(MAP_DEPTH));

  assign new_entry.beat  = in_ch.beat_pos;
  assign new_entry.tempo = in_ch.change_tempo;
  assign ins = in_xfer && (in_ch.command == CMD_INSERT) &&
               (in_ch.change_tempo != '0) && !full;

  for (genvar k = 0; k < MAP_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      tmb_cell u_cell (
        .clk        (clk),
        .ins        (ins),
        .new_entry  (new_entry),
        .prev_entry (new_entry),
        .prev_gt    (1'b0),
        .used       (count > CW'(k)),
        .at_end     (count == CW'(k)),
        .entry      (entries[k]),
        .gt         (gts[k])
      );
    end else begin : g_rest
      tmb_cell u_cell (
        .clk        (clk),
        .ins        (ins),
        .new_entry  (new_entry),
        .prev_entry (entries[k-1]),
        .prev_gt    (gts[k-1]),
        .used       (count > CW'(k)),
        .at_end     (count == CW'(k)),
        .entry      (entries[k]),
        .gt         (gts[k])
      );
    end
  end

  // segment walk: next change if it starts at or before the query beat
  assign rd    = entries[idx[IW-1:0]];
  assign take  = (idx < count) && (rd.beat <= q);
  assign delta = take ? (rd.beat - last) : (q - last);
  assign seg_tempo = tempo_cur;
  assign div_num = NUM_W'(delta) * NUM_W'(SECONDS_PER_MIN_Q7) +
                   NUM_W'(seg_tempo >> 1);
  assign div_start = (state == S_SEG) && (delta != '0) && (seg_tempo != '0);

  tmb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (seg_tempo),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign frame_sum = 53'(p_hi) + 53'((p_lo + 35'h8000) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_tempo <= 16'd15360;
      sample_rate   <= 19'd48000;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        2'(REG_DEFAULT_TEMPO): default_tempo <= cfg.data[TEMPO_W-1:0];
        2'(REG_SAMPLE_RATE):   sample_rate   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // a new result is loaded in S_DONE on the same transfer
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            q          <= in_ch.beat_pos;
            last       <= '0;
            tempo_cur  <= default_tempo;
            idx        <= '0;
            bad        <= 1'b0;
            acc        <= '0;
            res_tempo  <= '0;
            res_secs   <= '0;
            res_frame  <= '0;
            res_status <= ST_OK;
            case (in_ch.command)
              CMD_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              CMD_INSERT: begin
                if (in_ch.change_tempo == '0) begin
                  res_status <= ST_ZERO;
                end else if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
                state <= S_DONE;
              end
              CMD_CONVERT: state <= S_SEG;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_SEG: begin
          fin <= !take;
          if (take) begin
            last      <= rd.beat;
            tempo_cur <= rd.tempo;
            idx       <= idx + 1'b1;
          end
          if (delta != '0 && seg_tempo == '0) begin
            bad <= 1'b1;
          end
          if (div_start) begin
            state <= S_DIV;
          end else if (!take) begin
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            acc   <= acc + ACC_W'(div_quot);
            state <= fin ? S_MUL : S_SEG;
          end
        end
        S_MUL: begin
          if (acc > ACC_W'(MAX48)) begin
            secs <= MAX48;
            sat  <= 1'b1;
            p_hi <= 51'(MAX48[47:16]) * 51'(sample_rate);
            p_lo <= 35'(MAX48[15:0]) * 35'(sample_rate);
          end else begin
            secs <= acc[OUT_W-1:0];
            sat  <= 1'b0;
            p_hi <= 51'(acc[47:16]) * 51'(sample_rate);
            p_lo <= 35'(acc[15:0]) * 35'(sample_rate);
          end
          state <= S_SUM;
        end
        S_SUM: begin
          res_tempo <= tempo_cur;
          if (bad) begin
            res_status <= ST_ZERO;
          end else begin
            res_secs <= secs;
            if (frame_sum > 53'(MAX48)) begin
              res_frame  <= MAX48;
              res_status <= ST_SAT;
            end else begin
              res_frame  <= frame_sum[OUT_W-1:0];
              res_status <= sat ? ST_SAT : ST_OK;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.tempo_now       <= res_tempo;
            out_ch.elapsed_seconds <= res_secs;
            out_ch.sample_frame    <= res_frame;
            out_ch.status          <= res_status;
            out_ch.valid           <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
